### hdl/sprt_pkg.sv
// Shared page refcount table: package with field widths, codes and beat types.
// Used by every file of the block; depends on nothing.
package sprt_pkg;

    localparam int SPRT_TABLE_ENTRIES = 64;
    localparam int ID_W    = 32;
    localparam int FRAME_W = 20;
    localparam int COUNT_W = 8;
    localparam int SLOT_W  = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic FUNC_OPEN  = 1'b0;
    localparam logic FUNC_CLOSE = 1'b1;

    typedef enum logic [2:0] {
        ST_OPENED    = 3'd0,
        ST_ALLOCATED = 3'd1,
        ST_FULL      = 3'd2,
        ST_ALLOCFAIL = 3'd3,
        ST_HELD      = 3'd4,
        ST_FREED     = 3'd5,
        ST_NOTFOUND  = 3'd6,
        ST_INVALID   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ALLOC,
        WR_COUNT,
        WR_FREE
    } wr_op_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_RESOLVE
    } fsm_t;

    typedef struct packed {
        logic               func;
        logic [ID_W-1:0]    page_id;
        logic [FRAME_W-1:0] new_frame;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] ref_count;
    } rsp_t;

    // search token passed down the chain; indexes travel beside it
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] hit_frame;
        logic [COUNT_W-1:0] hit_count;
        logic               free_seen;
    } tok_t;

    // update broadcast to all cells; the addressed cell applies it
    typedef struct packed {
        wr_op_t             op;
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] count;
    } wr_t;

endpackage

### hdl/shared_page_refcount_table.sv
// Shared page refcount table: top level with sequencer and a chain of entry cells.
// Depends on sprt_pkg and sprt_cell.
//
// Usage:
//   req channel (req_valid/req_stall/req) carries one open or close request per beat.
//   rsp channel (rsp_valid/rsp_stall/rsp) returns exactly one result per request.
//   Each cell holds one entry. After a request is taken, a search token walks the
//   chain one cell per cycle, picking up the lowest matching entry and the lowest
//   empty entry. When it leaves the last cell the result is decided, the chosen
//   entry is updated and the result is registered.
//   A new request is not taken while one is in flight: req_stall is high from the
//   beat until the result is registered, after the token has walked the whole chain.
//   A result waiting under rsp_stall does not block the next request; the next
//   result is held back in its final step until the pending one has been taken.
//   Reset empties every entry and clears the result register.
module shared_page_refcount_table
    import sprt_pkg::*;
#(
    parameter int TABLE_ENTRIES = SPRT_TABLE_ENTRIES
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    fsm_t             state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    req_t             req_reg, req_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    tok_t             tok      [0:TABLE_ENTRIES];
    logic [IDX_W-1:0] hit_idx  [0:TABLE_ENTRIES];
    logic [IDX_W-1:0] free_idx [0:TABLE_ENTRIES];

    wr_t              wr_cmd, wr_bus;
    logic [IDX_W-1:0] wr_idx;
    rsp_t             res;
    logic             fire;
    tok_t             tok_end;

    assign tok[0]      = '0;
    assign hit_idx[0]  = '0;
    assign free_idx[0] = '0;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            sprt_cell #(
                .IDX_W    (IDX_W),
                .CELL_IDX (g)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .key          (req_reg.page_id),
                .wr           (wr_bus),
                .wr_idx       (wr_idx),
                .tok_in       (tok[g]),
                .hit_idx_in   (hit_idx[g]),
                .free_idx_in  (free_idx[g]),
                .tok_out      (tok[g+1]),
                .hit_idx_out  (hit_idx[g+1]),
                .free_idx_out (free_idx[g+1])
            );
        end
    endgenerate

    assign tok_end = tok[TABLE_ENTRIES];

    // decision from the finished token
    always_comb
    begin
        res            = '0;
        res.status     = ST_INVALID;
        wr_cmd.op      = WR_NONE;
        wr_cmd.frame   = req_reg.new_frame;
        wr_cmd.count   = '0;
        wr_idx         = hit_idx[TABLE_ENTRIES];
        if (req_reg.page_id == '0)
        begin
            res.status = ST_INVALID;
        end
        else if (req_reg.func == FUNC_OPEN)
        begin
            if (tok_end.hit)
            begin
                wr_cmd.op     = WR_COUNT;
                wr_cmd.count  = (tok_end.hit_count == COUNT_MAX) ?
                                COUNT_MAX : tok_end.hit_count + COUNT_W'(1);
                res.status    = ST_OPENED;
                res.slot      = SLOT_W'(hit_idx[TABLE_ENTRIES]);
                res.frame     = tok_end.hit_frame;
                res.ref_count = wr_cmd.count;
            end
            else if (!tok_end.free_seen)
            begin
                res.status = ST_FULL;
            end
            else if (req_reg.new_frame == '0)
            begin
                res.status = ST_ALLOCFAIL;
            end
            else
            begin
                wr_cmd.op     = WR_ALLOC;
                wr_cmd.count  = COUNT_W'(1);
                wr_idx        = free_idx[TABLE_ENTRIES];
                res.status    = ST_ALLOCATED;
                res.slot      = SLOT_W'(free_idx[TABLE_ENTRIES]);
                res.frame     = req_reg.new_frame;
                res.ref_count = COUNT_W'(1);
            end
        end
        else
        begin
            if (!tok_end.hit)
            begin
                res.status = ST_NOTFOUND;
            end
            else if (tok_end.hit_count <= COUNT_W'(1))
            begin
                wr_cmd.op  = WR_FREE;
                res.status = ST_FREED;
                res.slot   = SLOT_W'(hit_idx[TABLE_ENTRIES]);
                res.frame  = tok_end.hit_frame;
            end
            else
            begin
                wr_cmd.op     = WR_COUNT;
                wr_cmd.count  = tok_end.hit_count - COUNT_W'(1);
                res.status    = ST_HELD;
                res.slot      = SLOT_W'(hit_idx[TABLE_ENTRIES]);
                res.frame     = tok_end.hit_frame;
                res.ref_count = wr_cmd.count;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = FSM_SCAN;
                end
            end
            FSM_SCAN:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = FSM_RESOLVE;
                end
            end
            FSM_RESOLVE:
            begin
                if (!rsp_valid_reg)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req_stall = 1'b1;
        fire      = 1'b0;
        cnt_next  = cnt_reg;
        req_next  = req_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                req_stall = 1'b0;
                cnt_next  = '0;
                if (req_valid)
                begin
                    req_next = req;
                end
            end
            FSM_SCAN:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
            end
            FSM_RESOLVE:
            begin
                fire = !rsp_valid_reg;
            end
            default:
            begin
            end
        endcase
        wr_bus    = wr_cmd;
        if (!fire)
        begin
            wr_bus.op = WR_NONE;
        end
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_next       = res;
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            cnt_reg       <= '0;
            req_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            req_reg       <= req_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hdl/sprt_cell.sv
// One table entry (id, frame, count) plus one stage of the search token chain.
// Depends on sprt_pkg.
module sprt_cell
    import sprt_pkg::*;
#(
    parameter int IDX_W    = $clog2(SPRT_TABLE_ENTRIES),
    parameter int CELL_IDX = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ID_W-1:0]    key,
    input  wr_t                wr,
    input  logic [IDX_W-1:0]   wr_idx,
    input  tok_t               tok_in,
    input  logic [IDX_W-1:0]   hit_idx_in,
    input  logic [IDX_W-1:0]   free_idx_in,
    output tok_t               tok_out,
    output logic [IDX_W-1:0]   hit_idx_out,
    output logic [IDX_W-1:0]   free_idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [ID_W-1:0]    id_reg, id_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    tok_t               tok_reg, tok_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;

    always_comb
    begin
        id_next    = id_reg;
        frame_next = frame_reg;
        count_next = count_reg;
        if (wr.op != WR_NONE && wr_idx == MY_IDX)
        begin
            case (wr.op)
                WR_ALLOC:
                begin
                    id_next    = key;
                    frame_next = wr.frame;
                    count_next = wr.count;
                end
                WR_COUNT:
                begin
                    count_next = wr.count;
                end
                WR_FREE:
                begin
                    id_next    = '0;
                    frame_next = '0;
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // fold this entry into the token: lowest match and lowest empty win
    always_comb
    begin
        tok_next      = tok_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        if (!tok_in.hit && id_reg == key)
        begin
            tok_next.hit       = 1'b1;
            tok_next.hit_frame = frame_reg;
            tok_next.hit_count = count_reg;
            hit_idx_next       = MY_IDX;
        end
        if (!tok_in.free_seen && id_reg == '0)
        begin
            tok_next.free_seen = 1'b1;
            free_idx_next      = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg       <= '0;
            frame_reg    <= '0;
            count_reg    <= '0;
            tok_reg      <= '0;
            hit_idx_reg  <= '0;
            free_idx_reg <= '0;
        end
        else
        begin
            id_reg       <= id_next;
            frame_reg    <= frame_next;
            count_reg    <= count_next;
            tok_reg      <= tok_next;
            hit_idx_reg  <= hit_idx_next;
            free_idx_reg <= free_idx_next;
        end
    end

    assign tok_out      = tok_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;

endmodule

### hdl/sprt_chk.sv
// Port-level checker for the shared page refcount table, bound to the top level.
// Depends on sprt_pkg and shared_page_refcount_table.
module sprt_chk
    import sprt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // held result beat must not change
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("rsp beat changed under stall");

    // one request in flight: the beat after a request is always stalled
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous one in flight");

    // results that touch no entry report zeros
    a_no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_INVALID || rsp.status == ST_FULL ||
                      rsp.status == ST_ALLOCFAIL || rsp.status == ST_NOTFOUND)
        |-> rsp.slot == '0 && rsp.frame == '0 && rsp.ref_count == '0)
        else $error("nonzero fields on result without entry");

    // a new entry starts at one with a real frame; a freed one ends at zero
    a_count_edges: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_ALLOCATED || rsp.status == ST_FREED)
        |-> (rsp.status == ST_ALLOCATED && rsp.ref_count == 8'd1 && rsp.frame != '0) ||
            (rsp.status == ST_FREED && rsp.ref_count == '0))
        else $error("bad count on allocate or free");

endmodule

bind shared_page_refcount_table sprt_chk u_sprt_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

### test/shared_page_refcount_table_tb.sv
// Testbench for shared_page_refcount_table: directed and random open/close beats,
// checked against a scoreboard that keeps its own copy of the page table.
// Depends on sprt_pkg and the shared_page_refcount_table RTL.
`timescale 1ns / 1ps

module shared_page_refcount_table_tb;
    import sprt_pkg::*;

    // ~1250 beats, with sender gaps and receiver stalls, give the expected run
    // length; the limit allows several times that
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int POOL_SIZE = 12;

    class page_table_scoreboard;
        logic [ID_W-1:0]    entry_key   [SPRT_TABLE_ENTRIES];
        logic [FRAME_W-1:0] entry_frame [SPRT_TABLE_ENTRIES];
        logic [COUNT_W-1:0] entry_refs  [SPRT_TABLE_ENTRIES];
        rsp_t               awaited[$];
        int                 mismatches;

        function new();
            foreach (entry_key[i])
            begin
                entry_key[i]   = '0;
                entry_frame[i] = '0;
                entry_refs[i]  = '0;
            end
            mismatches = 0;
        endfunction

        // lowest entry holding key; key 0 finds the lowest empty entry
        function int find_entry(logic [ID_W-1:0] key);
            for (int i = 0; i < SPRT_TABLE_ENTRIES; i++)
            begin
                if (entry_key[i] == key)
                    return i;
            end
            return -1;
        endfunction

        function void note_request(req_t r);
            rsp_t want;
            int   hit;
            int   spare;
            want = '0;
            if (r.page_id == '0)
            begin
                want.status = ST_INVALID;
            end
            else
            begin
                hit = find_entry(r.page_id);
                if (r.func == FUNC_OPEN)
                begin
                    if (hit >= 0)
                    begin
                        if (entry_refs[hit] != COUNT_MAX)
                            entry_refs[hit] = entry_refs[hit] + 1'b1;
                        want.status    = ST_OPENED;
                        want.slot      = SLOT_W'(hit);
                        want.frame     = entry_frame[hit];
                        want.ref_count = entry_refs[hit];
                    end
                    else
                    begin
                        spare = find_entry('0);
                        if (spare < 0)
                            want.status = ST_FULL;
                        else if (r.new_frame == '0)
                            want.status = ST_ALLOCFAIL;
                        else
                        begin
                            entry_key[spare]   = r.page_id;
                            entry_frame[spare] = r.new_frame;
                            entry_refs[spare]  = COUNT_W'(1);
                            want.status    = ST_ALLOCATED;
                            want.slot      = SLOT_W'(spare);
                            want.frame     = r.new_frame;
                            want.ref_count = COUNT_W'(1);
                        end
                    end
                end
                else if (hit < 0)
                begin
                    want.status = ST_NOTFOUND;
                end
                else
                begin
                    if (entry_refs[hit] != '0)
                        entry_refs[hit] = entry_refs[hit] - 1'b1;
                    want.slot  = SLOT_W'(hit);
                    want.frame = entry_frame[hit];
                    if (entry_refs[hit] == '0)
                    begin
                        // freed: report the frame the entry held, then empty it
                        want.status      = ST_FREED;
                        entry_key[hit]   = '0;
                        entry_frame[hit] = '0;
                    end
                    else
                    begin
                        want.status    = ST_HELD;
                        want.ref_count = entry_refs[hit];
                    end
                end
            end
            awaited.push_back(want);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none actual %h", $time, got);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("slot", 32'(want.slot), 32'(got.slot));
            compare_field("frame", 32'(want.frame), 32'(got.frame));
            compare_field("ref_count", 32'(want.ref_count), 32'(got.ref_count));
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    page_table_scoreboard sb = new();
    bit                   no_idle = 1'b0;
    int unsigned          cycles  = 0;

    shared_page_refcount_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);
    end

    // result side: random stall bursts until the quiet tail of the run
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic send_req(input logic func, input logic [ID_W-1:0] page_id,
                            input logic [FRAME_W-1:0] frame);
        req_t beat;
        beat.func      = func;
        beat.page_id   = page_id;
        beat.new_frame = frame;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req       <= beat;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        sb.note_request(beat);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        logic [ID_W-1:0]    pool [POOL_SIZE];
        logic [ID_W-1:0]    fill_ids[$];
        logic [ID_W-1:0]    page_id;
        logic [ID_W-1:0]    hot_id;
        logic [FRAME_W-1:0] frame;
        int                 pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reserved id, miss, allocator failure, alloc, reopen, held, freed
        send_req(FUNC_OPEN,  32'h0000_0000, 20'hFFFFF);
        send_req(FUNC_CLOSE, 32'h0000_0000, 20'h00000);
        send_req(FUNC_CLOSE, 32'h8000_0001, 20'h12345);
        send_req(FUNC_OPEN,  32'h8000_0001, 20'h00000);
        send_req(FUNC_OPEN,  32'h8000_0001, 20'hFFFFF);
        send_req(FUNC_OPEN,  32'hFFFF_FFFF, 20'h00001);
        send_req(FUNC_OPEN,  32'h8000_0001, 20'h00000);
        send_req(FUNC_CLOSE, 32'h8000_0001, 20'hFFFFF);
        send_req(FUNC_CLOSE, 32'h8000_0001, 20'h00000);
        send_req(FUNC_OPEN,  32'h0000_0001, 20'h80000);
        send_req(FUNC_CLOSE, 32'hFFFF_FFFF, 20'h00000);
        send_req(FUNC_CLOSE, 32'hFFFF_FFFF, 20'h00000);
        send_req(FUNC_OPEN,  32'h0000_0000, 20'h00000);
        send_req(FUNC_CLOSE, 32'h0000_0001, 20'h7FFFF);
        drain();

        // mixed traffic over a small id pool so opens and closes meet
        foreach (pool[i])
        begin
            pool[i] = $urandom;
            if (pool[i] == '0)
                pool[i] = 32'h5A5A_0001;
        end
        for (int n = 0; n < 560; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                page_id = '0;
            else if (pick < 15)
                page_id = $urandom;
            else
                page_id = pool[$urandom_range(0, POOL_SIZE - 1)];
            frame = ($urandom_range(0, 11) == 0) ? '0 : FRAME_W'($urandom);
            send_req(($urandom_range(0, 99) < 55) ? FUNC_OPEN : FUNC_CLOSE, page_id, frame);
        end
        drain();

        // fill the table past full, then close each of those ids once in random order
        for (int n = 0; n < SPRT_TABLE_ENTRIES + 2; n++)
        begin
            page_id = $urandom;
            if (page_id == '0)
                page_id = 32'hC0DE_0001;
            fill_ids.push_back(page_id);
            send_req(FUNC_OPEN, page_id, FRAME_W'($urandom_range(1, 20'hFFFFF)));
        end
        // full wins over a zero frame
        send_req(FUNC_OPEN, 32'h7FFF_FFFE, 20'h00000);
        send_req(FUNC_OPEN, 32'h0F0F_0F0F, 20'h00000);
        send_req(FUNC_OPEN, 32'h3333_3333, 20'hAAAAA);
        for (int n = 0; n < 4; n++)
            send_req(FUNC_OPEN, fill_ids[n], '0);
        send_req(FUNC_OPEN, pool[0], 20'h55555);
        fill_ids.shuffle();
        foreach (fill_ids[i])
            send_req(FUNC_CLOSE, fill_ids[i], FRAME_W'($urandom));
        drain();

        // one id driven into count saturation and all the way back down
        hot_id = $urandom;
        if (hot_id == '0)
            hot_id = 32'h0BAD_F00D;
        for (int n = 0; n < 258; n++)
            send_req(FUNC_OPEN, hot_id, FRAME_W'($urandom_range(1, 20'hFFFFF)));
        for (int n = 0; n < 256; n++)
        begin
            if (n == 136)
                no_idle = 1'b1;
            send_req(FUNC_CLOSE, hot_id, FRAME_W'($urandom));
        end

        drain();
        repeat (80) @(posedge clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
hdl/sprt_pkg.sv
hdl/sprt_cell.sv
hdl/shared_page_refcount_table.sv
hdl/sprt_chk.sv
test/shared_page_refcount_table_tb.sv
